@@ rtl/esu_pkg.sv @@
// Package for the escape sequence unslasher: byte codes, parser mode codes,
// the result group type and small helper functions.
// No dependencies.
package esu_pkg;

  // Parser modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Control bytes
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_HT  = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  localparam int unsigned MAX_BYTES  = 4;
  localparam logic [2:0]  DIGITS_X   = 3'd2;
  localparam logic [2:0]  DIGITS_U   = 3'd4;
  localparam logic [15:0] REPL_CHAR  = 16'hFFFD;

  // Up to four output bytes caused by one input byte
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
  } group_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic group_t push_byte(group_t g, logic [7:0] v);
    group_t r;
    r = g;
    if (g.count < 3'(MAX_BYTES)) begin
      r.bytes[g.count[1:0]] = v;
      r.count = g.count + 3'd1;
    end
    return r;
  endfunction

  // Emit a pending hex value as UTF-8, or the letter when empty or zero
  function automatic group_t finish_hex(group_t g, logic short_form,
                                        logic [2:0] digits, logic [15:0] code);
    group_t     r;
    logic [15:0] v;
    r = g;
    v = code;
    if (digits == 3'd0 || v == 16'd0) begin
      r = push_byte(r, short_form ? CH_X : CH_U);
    end else if (v < 16'h0080) begin
      r = push_byte(r, v[7:0]);
    end else if (v < 16'h0800) begin
      r = push_byte(r, {3'b110, v[10:6]});
      r = push_byte(r, {2'b10, v[5:0]});
    end else begin
      if (v >= 16'hD800 && v <= 16'hDFFF) v = REPL_CHAR;
      r = push_byte(r, {4'b1110, v[15:12]});
      r = push_byte(r, {2'b10, v[11:6]});
      r = push_byte(r, {2'b10, v[5:0]});
    end
    return r;
  endfunction

endpackage

@@ rtl/esu_in_if.sv @@
// Input channel of the unslasher: one text byte per request.
// Depends on nothing.
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ rtl/esu_out_if.sv @@
// Output channel of the unslasher: one decoded byte per request.
// Depends on nothing.
interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

@@ rtl/esu_decode.sv @@
// Escape parser: holds the parse state and turns one input byte into a
// group of up to four output bytes. Depends on esu_pkg.
module esu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      in_byte,
  input  logic            last_byte,
  output esu_pkg::group_t group
);
  import esu_pkg::*;

  logic [1:0]  parse_mode, parse_mode_next;
  logic        short_form, short_form_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] code_value, code_value_next;

  logic [4:0]  hex;
  logic [2:0]  digits_inc;

  assign hex        = hex_value(in_byte);
  assign digits_inc = digit_count + 3'd1;

  always_comb begin
    group            = '0;
    parse_mode_next  = parse_mode;
    short_form_next  = short_form;
    digit_count_next = digit_count;
    code_value_next  = code_value;

    case (parse_mode)
      MODE_ESC: begin
        parse_mode_next = MODE_TEXT;
        case (in_byte)
          CH_A:      group = push_byte(group, CTL_BEL);
          CH_B:      group = push_byte(group, CTL_BS);
          CH_F:      group = push_byte(group, CTL_FF);
          CH_N:      group = push_byte(group, CTL_LF);
          CH_R:      group = push_byte(group, CTL_CR);
          CH_T:      group = push_byte(group, CTL_HT);
          CH_V:      group = push_byte(group, CTL_VT);
          CH_BSLASH: begin
            group = push_byte(group, CH_BSLASH);
            group = push_byte(group, CH_BSLASH);
          end
          CH_X, CH_U: begin
            parse_mode_next  = MODE_HEX;
            short_form_next  = (in_byte == CH_X);
            digit_count_next = 3'd0;
            code_value_next  = 16'd0;
          end
          default: begin
            if (in_byte >= CH_ONE && in_byte <= CH_NINE) group = push_byte(group, CH_DOLLAR);
            group = push_byte(group, in_byte);
          end
        endcase
      end
      MODE_HEX: begin
        if (hex[4]) begin
          code_value_next  = {code_value[11:0], hex[3:0]};
          digit_count_next = digits_inc;
          if (digits_inc >= (short_form ? DIGITS_X : DIGITS_U)) begin
            group            = finish_hex(group, short_form, digits_inc, code_value_next);
            parse_mode_next  = MODE_TEXT;
            digit_count_next = 3'd0;
            code_value_next  = 16'd0;
          end
        end else begin
          group            = finish_hex(group, short_form, digit_count, code_value);
          digit_count_next = 3'd0;
          code_value_next  = 16'd0;
          // ending byte is ordinary text again
          if (in_byte == CH_BSLASH) parse_mode_next = MODE_ESC;
          else begin
            parse_mode_next = MODE_TEXT;
            group = push_byte(group, in_byte);
          end
        end
      end
      default: begin
        if (in_byte == CH_BSLASH) parse_mode_next = MODE_ESC;
        else begin
          parse_mode_next = MODE_TEXT;
          group = push_byte(group, in_byte);
        end
      end
    endcase

    // end of text: flush hex, drop lone backslash
    if (last_byte) begin
      if (parse_mode_next == MODE_HEX)
        group = finish_hex(group, short_form_next, digit_count_next, code_value_next);
      parse_mode_next  = MODE_TEXT;
      digit_count_next = 3'd0;
      code_value_next  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode  <= MODE_TEXT;
      short_form  <= 1'b0;
      digit_count <= 3'd0;
      code_value  <= 16'd0;
    end else if (take) begin
      parse_mode  <= parse_mode_next;
      short_form  <= short_form_next;
      digit_count <= digit_count_next;
      code_value  <= code_value_next;
    end
  end

`ifndef SYNTHESIS
  a_hex_digits_bounded: assert property (@(posedge clk) disable iff (rst)
    parse_mode == MODE_HEX |-> digit_count < (short_form ? DIGITS_X : DIGITS_U))
    else $error("hex run longer than its form allows");
  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    parse_mode != MODE_HEX |-> (digit_count == 3'd0 && code_value == 16'd0))
    else $error("hex accumulator not cleared outside hex mode");
  a_last_returns_text: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> parse_mode == MODE_TEXT)
    else $error("parser not back in text mode after final byte");
`endif

endmodule

@@ rtl/escape_sequence_unslasher.sv @@
// Top level of the escape sequence unslasher: parser plus result group
// register and byte serializer. Depends on esu_pkg, esu_in_if, esu_out_if,
// esu_decode.
//
// Usage:
//   text    : sink channel, one byte of replacement text per request, with
//             last_byte marking the final byte of a text (flushes a pending
//             hex run, drops a trailing lone backslash).
//   decoded : source channel, one decoded byte per request; run_end is set
//             on the last byte caused by one input byte.
// Each input byte yields zero to four output bytes. The parser decodes the
// byte in the cycle it is accepted and loads the group register; the first
// output byte is offered the next cycle. The group drains one byte per cycle
// while the receiver is ready, and a new input byte is taken in the same
// cycle as the final byte of the current group leaves, so input throughput
// is one byte per cycle, with the receiver ready, whenever each input makes
// at most one output byte; else the next input waits until the group drains.
// Reset (rst, synchronous) returns the parser to text mode and empties the
// group register. While a group waits on a stalled receiver, its byte holds
// and every input byte waits too, including bytes that cause no output.
module escape_sequence_unslasher (
  input  logic clk,
  input  logic rst,
  esu_in_if.sink    text,
  esu_out_if.source decoded
);
  import esu_pkg::*;

  group_t     group;
  logic       take;
  logic       out_take;
  logic       drain_done;

  // group register: bytes, index of the byte on offer, index of the last
  logic                      grp_valid;
  logic [MAX_BYTES-1:0][7:0] grp_bytes;
  logic [1:0]                grp_idx;
  logic [1:0]                grp_last;

  esu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (text.in_byte),
    .last_byte (text.last_byte),
    .group     (group)
  );

  assign out_take   = decoded.valid && decoded.ready;
  assign drain_done = out_take && (grp_idx == grp_last);

  // input waits while a group is on offer, except as its final byte leaves
  assign text.ready = !grp_valid || drain_done;
  assign take       = text.valid && text.ready;

  assign decoded.valid    = grp_valid;
  assign decoded.out_byte = grp_bytes[grp_idx];
  assign decoded.run_end  = (grp_idx == grp_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
      grp_last  <= 2'd0;
    end else if (take && group.count != 3'd0) begin
      grp_valid <= 1'b1;
      grp_idx   <= 2'd0;
      grp_last  <= 2'(group.count - 3'd1);
    end else if (drain_done) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
    end else if (out_take) begin
      grp_idx   <= grp_idx + 2'd1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (take && group.count != 3'd0) grp_bytes <= group.bytes;
  end

`ifndef SYNTHESIS
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> grp_idx <= grp_last)
    else $error("output index past end of group");
  a_load_shows_byte: assert property (@(posedge clk) disable iff (rst)
    take && group.count != 3'd0 |=> grp_valid && grp_idx == 2'd0)
    else $error("loaded group not offered");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    take && grp_valid |-> drain_done)
    else $error("input taken while group still draining");
  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    out_take && !decoded.run_end |=> grp_idx == $past(grp_idx) + 2'd1)
    else $error("output index did not advance");
`endif

endmodule
